[src/bcu_pkg.sv]
// bcu_pkg: shared sizes, status codes and controller/datapath structs
// for the binomial coefficient unit. No dependencies.

package bcu_pkg;

  // largest pool size the row store can hold
  localparam int MAX_N     = 64;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int ROW_DEPTH = MAX_N + 1;
  localparam int IDX_W     = $clog2(ROW_DEPTH);

  localparam logic signed [DATA_W-1:0] MAX_N_S = DATA_W'(MAX_N);

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_INVALID   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_TOO_LARGE = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request operands
    logic report_err;  // post an error result for the request at the ports
    logic init;        // write row entry 0 with one
    logic prime;       // open a row: fetch the top entry, clear the held word
    logic add;         // one pascal addition, walking down the row
    logic fetch;       // read the entry at column k
    logic finish;      // post the fetched entry as the result
  } bcu_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic req_ok;    // request at the ports is in range
    logic n_zero;    // captured pool size is zero
    logic row_last;  // current row is row n
    logic col_last;  // current column is one
  } bcu_stat_t;

endpackage

[src/bcu_ram.sv]
// bcu_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module bcu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bcu_ctrl.sv]
// bcu_ctrl: sequencer for the pascal row build, one addition per cycle.
// Depends on bcu_pkg for the command and status structs.

module bcu_ctrl import bcu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  bcu_stat_t stat,
  output bcu_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_PRIME,
    S_ADD,
    S_READ,
    S_LATCH
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.req_ok) begin
            state_next = S_INIT;
          end else begin
            cmd.report_err = 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = stat.n_zero ? S_READ : S_PRIME;
      end
      S_PRIME: begin
        cmd.prime  = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (stat.col_last) begin
          state_next = stat.row_last ? S_READ : S_PRIME;
        end
      end
      S_READ: begin
        cmd.fetch  = 1'b1;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

[src/bcu_dpath.sv]
// bcu_dpath: operand check, row/column counters, adder, row store and
// result registers. Depends on bcu_pkg and bcu_ram.

module bcu_dpath import bcu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] chosen_count,
  input  logic signed [DATA_W-1:0] pool_size,
  input  bcu_cmd_t                 cmd,
  output bcu_stat_t                stat,
  output logic signed [DATA_W-1:0] coefficient,
  output logic [STAT_W-1:0]        status,
  output logic                     done
);

  logic [IDX_W-1:0]  k_reg;
  logic [IDX_W-1:0]  n_reg;
  logic [IDX_W-1:0]  row_counter;
  logic [IDX_W-1:0]  column_counter;
  logic [DATA_W-1:0] held;
  logic              invalid;
  logic              too_large;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  // operand check on the request at the ports
  assign invalid   = (chosen_count < 0) || (pool_size < 0) || (pool_size < chosen_count);
  assign too_large = (pool_size > MAX_N_S);

  assign stat.req_ok   = !invalid && !too_large;
  assign stat.n_zero   = (n_reg == '0);
  assign stat.row_last = (row_counter == n_reg);
  assign stat.col_last = (column_counter == IDX_W'(1));

  // row store ports: write entry j with held + entry j-1, fetch entry j-2
  assign we    = cmd.init || cmd.add;
  assign waddr = cmd.init ? '0 : column_counter;
  assign wdata = cmd.init ? DATA_W'(1) : held + rdata;

  always_comb begin
    priority if (cmd.prime) begin
      raddr = row_counter - IDX_W'(1);
    end else if (cmd.add) begin
      raddr = (column_counter >= IDX_W'(2)) ? column_counter - IDX_W'(2) : '0;
    end else begin
      raddr = k_reg;
    end
  end

  bcu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // operands, counters and the word carried down the row
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      column_counter <= '0;
    end else begin
      if (cmd.init) begin
        // row 0 needs no build, so the counter stays at zero
        row_counter <= stat.n_zero ? '0 : IDX_W'(1);
      end else if (cmd.add && stat.col_last && !stat.row_last) begin
        row_counter <= row_counter + IDX_W'(1);
      end
      if (cmd.prime) begin
        column_counter <= row_counter;
      end else if (cmd.add) begin
        column_counter <= column_counter - IDX_W'(1);
      end
    end
    if (cmd.load) begin
      k_reg <= chosen_count[IDX_W-1:0];
      n_reg <= pool_size[IDX_W-1:0];
    end
    if (cmd.prime) begin
      held <= '0;
    end else if (cmd.add) begin
      held <= rdata;
    end
  end

  // result registers, strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report_err || cmd.finish;
    end
    if (cmd.report_err) begin
      coefficient <= '0;
      status      <= invalid ? STATUS_INVALID : STATUS_TOO_LARGE;
    end else if (cmd.finish) begin
      coefficient <= rdata;
      status      <= STATUS_OK;
    end
  end

endmodule

[src/binomial_coefficient_unit.sv]
// binomial_coefficient_unit: top level, C(n,k) by pascal row additions.
// Depends on bcu_pkg, bcu_ctrl, bcu_dpath (which holds bcu_ram).
//
//   channel   ports                              handshake
//   request   chosen_count, pool_size            start && !busy
//   result    coefficient, status                done, one cycle, no stall
//
// A good request keeps busy high through the init, row build, read and latch
// states; the result strobe follows in the next cycle, when a new request may
// be taken. The build does one addition per cycle through the single row-store
// read port, with a prime step to open each row. A rejected request posts its
// result in the cycle after it is taken and busy stays low.
// Reset is synchronous; no clearing pass is needed since each request
// writes every row entry before reading it. The receiver cannot stall done.

module binomial_coefficient_unit import bcu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] chosen_count,
  input  logic signed [DATA_W-1:0] pool_size,
  output logic                     done,
  output logic signed [DATA_W-1:0] coefficient,
  output logic [STAT_W-1:0]        status
);

  bcu_cmd_t  cmd;
  bcu_stat_t stat;

  // sequencer
  bcu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // arithmetic and row store
  bcu_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .chosen_count (chosen_count),
    .pool_size    (pool_size),
    .cmd          (cmd),
    .stat         (stat),
    .coefficient  (coefficient),
    .status       (status),
    .done         (done)
  );

  // an error result follows its transaction in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> $past(start && !busy))
    else $error("error result without a request one cycle before");

  // error results carry a zero value
  assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> (coefficient == '0))
    else $error("error result with nonzero coefficient");

  // end of a row build posts the result
  assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done && status == STATUS_OK))
    else $error("busy dropped without a good result");

  // an in-range request starts a row build
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && chosen_count >= 0 && pool_size >= chosen_count
     && pool_size <= MAX_N_S) |=> busy)
    else $error("in-range request did not start a build");

endmodule
